>>> rtl/assert_macros.svh
// Assertion macros for the top-level RTL file, the only one that carries checks.
// Included by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Clocked check that is switched off while reset is held.
`define FMP_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);
// Clocked check that also holds during reset.
`define FMP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FMP_ASSERT(lbl, clk, rstn, prop, msg)
`define FMP_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

>>> rtl/fmp_pkg.sv
// Shared types and constants for the Fibonacci residue block.
// No dependencies; used by every module of the block.
package fmp_pkg;

    localparam int INDEX_W        = 40;
    localparam int RESIDUE_W      = 16;
    localparam int MOD_W          = 16;
    localparam int MU_W           = 32;
    localparam int INDEX_BITS_DEF = 40;
    localparam int RECIP_STEPS    = 33;
    localparam logic [MOD_W-1:0] MOD_RESET = 16'd10000;
    localparam logic [MOD_W-1:0] MOD_MIN   = 16'd2;

    // Products of one exponent bit, in issue order. The first four update the
    // accumulator, the last four square the base. Odd codes close a sum pair.
    typedef enum logic [2:0] {
        PROD_AA    = 3'd0,
        PROD_BB    = 3'd1,
        PROD_AB    = 3'd2,
        PROD_BC    = 3'd3,
        PROD_SQ_AA = 3'd4,
        PROD_SQ_BB = 3'd5,
        PROD_SQ_AB = 3'd6,
        PROD_SQ_BC = 3'd7
    } fmp_prod_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CHECK,
        ST_PREP,
        ST_ISSUE,
        ST_WAIT,
        ST_DONE
    } fmp_state_t;

    // Controller to datapath.
    typedef struct packed {
        logic      load;
        logic      prep;
        logic      issue;
        fmp_prod_t sel;
        logic      shift;
        logic      emit;
    } fmp_cmd_t;

    // Datapath to controller.
    typedef struct packed {
        logic finish;
        logic exp_lsb;
        logic pipe_busy;
        logic recip_busy;
    } fmp_stat_t;

endpackage

>>> rtl/fibonacci_mod_matrix_power.sv
// Top level of the Fibonacci residue block: F(n) mod a configured modulus.
// Depends on fmp_pkg, fmp_ctrl, fmp_datapath and assert_macros.svh.
//
//  channel  | dir | handshake          | word
//  ---------+-----+--------------------+---------------------------------
//  s_       | in  | s_tvalid/s_tready  | s_tdata[39:0]  index
//  m_       | out | m_tvalid/m_tready  | m_tdata[15:0]  residue
//  cfg_     | in  | cfg_we             | cfg_wdata[15:0] modulus
//
// Each exponent bit issues four or eight products into the single pipelined
// multiply-reduce unit, then waits for it to drain.
// After reset and after each modulus write, s_tready stays low while the
// Barrett reciprocal is formed. A finished word waits in the output
// register while the next index is accepted and worked on.
`include "assert_macros.svh"

module fibonacci_mod_matrix_power #(
    parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fmp_pkg::MOD_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [fmp_pkg::INDEX_W-1:0]   s_tdata,   // [39:0] index
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [fmp_pkg::RESIDUE_W-1:0] m_tdata    // [15:0] residue
);

    fmp_pkg::fmp_cmd_t  cmd;
    fmp_pkg::fmp_stat_t stat;
    logic [fmp_pkg::MOD_W-1:0] modulus;

    fmp_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fmp_datapath #(
        .INDEX_BITS (INDEX_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .index     (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .residue   (m_tdata),
        .modulus   (modulus)
    );

    // No index is taken while the reciprocal is being formed.
    `FMP_ASSERT(a_no_accept_in_recip, aclk, aresetn, stat.recip_busy |-> !s_tready, "index accepted during reciprocal")
    // A modulus write always restarts the reciprocal.
    `FMP_ASSERT(a_cfg_starts_recip, aclk, aresetn, cfg_we |=> stat.recip_busy, "modulus write did not restart reciprocal")
    // One index at a time: after an accept the input side closes.
    `FMP_ASSERT(a_single_item, aclk, aresetn, (s_tvalid && s_tready) |=> !s_tready, "second index accepted while busy")
    // A residue is always reduced below a meaningful modulus.
    `FMP_ASSERT(a_residue_range, aclk, aresetn, (m_tvalid && (modulus >= fmp_pkg::MOD_MIN)) |-> (m_tdata < modulus), "residue not reduced")

endmodule

>>> rtl/fmp_mulmod.sv
// Pipelined modular multiplier using Barrett reduction with a precomputed
// reciprocal. Depends on fmp_pkg.
module fmp_mulmod (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    input  fmp_pkg::fmp_prod_t            in_tag,
    input  logic [fmp_pkg::MOD_W-1:0]     op_a,
    input  logic [fmp_pkg::MOD_W-1:0]     op_b,
    input  logic [fmp_pkg::MOD_W-1:0]     modulus,
    input  logic [fmp_pkg::MU_W-1:0]      mu,
    output logic                          out_valid,
    output fmp_pkg::fmp_prod_t            out_tag,
    output logic [fmp_pkg::MOD_W-1:0]     out_res,
    output logic                          busy
);

    localparam int PW = 2 * fmp_pkg::MOD_W;

    logic s1_valid_reg, s2_valid_reg, s3_valid_reg, s4_valid_reg;
    fmp_pkg::fmp_prod_t s1_tag_reg, s2_tag_reg, s3_tag_reg, s4_tag_reg;
    logic [PW-1:0] s1_prod_reg, s2_prod_reg, s3_prod_reg;
    logic [PW-1:0] s2_q_reg, s3_qm_reg;
    logic [fmp_pkg::MOD_W-1:0] s4_res_reg;

    logic [2*PW-1:0]                  qmu_full;
    logic [PW+fmp_pkg::MOD_W-1:0]     qm_full;
    logic [PW-1:0]                    diff;
    logic [fmp_pkg::MOD_W:0]          diff_lo;
    logic [fmp_pkg::MOD_W:0]          mod_ext;
    logic [fmp_pkg::MOD_W-1:0]        res_next;

    // Quotient estimate and final correction. The estimate is low by at most
    // one, so the remainder stays below twice the modulus.
    always_comb begin
        qmu_full = {{PW{1'b0}}, s1_prod_reg} * {{(2*PW-fmp_pkg::MU_W){1'b0}}, mu};
        qm_full  = {{fmp_pkg::MOD_W{1'b0}}, s2_q_reg} * {{PW{1'b0}}, modulus};
        diff     = s3_prod_reg - s3_qm_reg;
        diff_lo  = diff[fmp_pkg::MOD_W:0];
        mod_ext  = {1'b0, modulus};
        if (diff_lo >= mod_ext) begin
            res_next = fmp_pkg::MOD_W'(diff_lo - mod_ext);
        end else begin
            res_next = diff_lo[fmp_pkg::MOD_W-1:0];
        end
    end

    // Stage valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            s4_valid_reg <= 1'b0;
        end else begin
            s1_valid_reg <= in_valid;
            s2_valid_reg <= s1_valid_reg;
            s3_valid_reg <= s2_valid_reg;
            s4_valid_reg <= s3_valid_reg;
        end
    end

    // Stage payload: product, quotient, quotient times modulus, remainder.
    always_ff @(posedge aclk) begin
        s1_tag_reg  <= in_tag;
        s1_prod_reg <= {{fmp_pkg::MOD_W{1'b0}}, op_a} * {{fmp_pkg::MOD_W{1'b0}}, op_b};
        s2_tag_reg  <= s1_tag_reg;
        s2_prod_reg <= s1_prod_reg;
        s2_q_reg    <= qmu_full[2*PW-1:PW];
        s3_tag_reg  <= s2_tag_reg;
        s3_prod_reg <= s2_prod_reg;
        s3_qm_reg   <= qm_full[PW-1:0];
        s4_tag_reg  <= s3_tag_reg;
        s4_res_reg  <= res_next;
    end

    assign out_valid = s4_valid_reg;
    assign out_tag   = s4_tag_reg;
    assign out_res   = s4_res_reg;
    assign busy      = s1_valid_reg | s2_valid_reg | s3_valid_reg | s4_valid_reg;

endmodule

>>> rtl/fmp_recip.sv
// Restoring divider that forms floor(2^32 / modulus) for Barrett reduction.
// Depends on fmp_pkg.
module fmp_recip (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      start,
    input  logic [fmp_pkg::MOD_W-1:0] divisor,
    output logic [fmp_pkg::MU_W-1:0]  mu,
    output logic                      busy
);

    localparam int CNT_W = $clog2(fmp_pkg::RECIP_STEPS + 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(fmp_pkg::RECIP_STEPS);

    logic [CNT_W-1:0]          cnt_reg;
    logic [fmp_pkg::MOD_W-1:0] rem_reg, rem_next;
    logic [fmp_pkg::MU_W-1:0]  quo_reg;
    logic [fmp_pkg::MOD_W:0]   trial;
    logic                      ge;

    // One quotient bit per cycle. The dividend is a single one followed by
    // zeros, so only the first step shifts in a one.
    always_comb begin
        trial = {rem_reg, (cnt_reg == CNT_FULL)};
        ge    = (trial >= {1'b0, divisor});
        if (ge) begin
            rem_next = fmp_pkg::MOD_W'(trial - {1'b0, divisor});
        end else begin
            rem_next = trial[fmp_pkg::MOD_W-1:0];
        end
    end

    // Step counter and remainder; a new modulus restarts the division.
    always_ff @(posedge aclk) begin
        if (!aresetn || start) begin
            cnt_reg <= CNT_FULL;
            rem_reg <= '0;
        end else if (cnt_reg != '0) begin
            cnt_reg <= cnt_reg - CNT_W'(1);
            rem_reg <= rem_next;
        end
    end

    // Quotient shift register.
    always_ff @(posedge aclk) begin
        if (cnt_reg != '0) begin
            quo_reg <= {quo_reg[fmp_pkg::MU_W-2:0], ge};
        end
    end

    assign mu   = quo_reg;
    assign busy = (cnt_reg != '0);

endmodule

>>> rtl/fmp_datapath.sv
// Datapath: modulus register, exponent, accumulator and base matrices, the
// shared multiply-reduce unit and the pair summer. Depends on fmp_pkg,
// fmp_mulmod and fmp_recip.
module fmp_datapath #(
    parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fmp_pkg::MOD_W-1:0]     cfg_wdata,
    input  logic [fmp_pkg::INDEX_W-1:0]   index,
    input  fmp_pkg::fmp_cmd_t             cmd,
    output fmp_pkg::fmp_stat_t            stat,
    output logic [fmp_pkg::RESIDUE_W-1:0] residue,
    output logic [fmp_pkg::MOD_W-1:0]     modulus
);

    localparam int USE_BITS = (INDEX_BITS < fmp_pkg::INDEX_W) ? INDEX_BITS
                                                               : fmp_pkg::INDEX_W;
    localparam int MW = fmp_pkg::MOD_W;

    logic [MW-1:0]       modulus_reg;
    logic [USE_BITS-1:0] exp_reg;
    logic                zero_reg;
    // Each matrix is a power of [[1,1],[1,0]], kept as its top row; the
    // bottom-right entry is the difference of the two.
    logic [MW-1:0] acc_a_reg, acc_b_reg, base_a_reg, base_b_reg, base_c_reg;
    logic [MW-1:0] hold_reg;
    logic [fmp_pkg::RESIDUE_W-1:0] residue_reg;

    logic [USE_BITS-1:0]       n_idx;
    logic [MW-1:0]             base_c_next;
    logic [MW-1:0]             op_a, op_b;
    logic [fmp_pkg::MU_W-1:0]  mu;
    logic                      recip_busy, mm_valid, mm_busy;
    fmp_pkg::fmp_prod_t        mm_tag;
    logic [MW-1:0]             mm_res;
    logic [MW:0]               pair_sum;
    logic [MW-1:0]             pair_mod;

    assign n_idx = index[USE_BITS-1:0];

    // Modulus register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            modulus_reg <= fmp_pkg::MOD_RESET;
        end else if (cfg_we) begin
            modulus_reg <= cfg_wdata;
        end
    end

    fmp_recip u_recip (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cfg_we),
        .divisor (modulus_reg),
        .mu      (mu),
        .busy    (recip_busy)
    );

    // Bottom-right entry of the base: (a - b) mod m.
    always_comb begin
        base_c_next = base_a_reg - base_b_reg;
        if (base_a_reg < base_b_reg) begin
            base_c_next = base_c_next + modulus_reg;
        end
    end

    // Operand selection for the product being issued.
    always_comb begin
        unique case (cmd.sel)
            fmp_pkg::PROD_AA:    begin op_a = acc_a_reg;  op_b = base_a_reg; end
            fmp_pkg::PROD_BB:    begin op_a = acc_b_reg;  op_b = base_b_reg; end
            fmp_pkg::PROD_AB:    begin op_a = acc_a_reg;  op_b = base_b_reg; end
            fmp_pkg::PROD_BC:    begin op_a = acc_b_reg;  op_b = base_c_reg; end
            fmp_pkg::PROD_SQ_AA: begin op_a = base_a_reg; op_b = base_a_reg; end
            fmp_pkg::PROD_SQ_BB: begin op_a = base_b_reg; op_b = base_b_reg; end
            fmp_pkg::PROD_SQ_AB: begin op_a = base_a_reg; op_b = base_b_reg; end
            fmp_pkg::PROD_SQ_BC: begin op_a = base_b_reg; op_b = base_c_reg; end
            default:             begin op_a = '0;         op_b = '0;         end
        endcase
    end

    fmp_mulmod u_mulmod (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (cmd.issue),
        .in_tag    (cmd.sel),
        .op_a      (op_a),
        .op_b      (op_b),
        .modulus   (modulus_reg),
        .mu        (mu),
        .out_valid (mm_valid),
        .out_tag   (mm_tag),
        .out_res   (mm_res),
        .busy      (mm_busy)
    );

    // Modular sum of a held product and the one that closes its pair.
    always_comb begin
        pair_sum = {1'b0, hold_reg} + {1'b0, mm_res};
        if (pair_sum >= {1'b0, modulus_reg}) begin
            pair_mod = MW'(pair_sum - {1'b0, modulus_reg});
        end else begin
            pair_mod = pair_sum[MW-1:0];
        end
    end

    // Working registers. An entry is rewritten only after every product that
    // reads it has entered the multiplier.
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            exp_reg    <= n_idx - USE_BITS'(1);
            zero_reg   <= (n_idx == '0) || (modulus_reg < fmp_pkg::MOD_MIN);
            acc_a_reg  <= MW'(1);
            acc_b_reg  <= '0;
            base_a_reg <= MW'(1);
            base_b_reg <= MW'(1);
        end
        if (cmd.prep) begin
            base_c_reg <= base_c_next;
        end
        if (cmd.shift) begin
            exp_reg <= exp_reg >> 1;
        end
        if (mm_valid) begin
            case (mm_tag) inside
                fmp_pkg::PROD_AA, fmp_pkg::PROD_AB,
                fmp_pkg::PROD_SQ_AA, fmp_pkg::PROD_SQ_AB: hold_reg <= mm_res;
                fmp_pkg::PROD_BB:    acc_a_reg  <= pair_mod;
                fmp_pkg::PROD_BC:    acc_b_reg  <= pair_mod;
                fmp_pkg::PROD_SQ_BB: base_a_reg <= pair_mod;
                fmp_pkg::PROD_SQ_BC: base_b_reg <= pair_mod;
                default: ;
            endcase
        end
        if (cmd.emit) begin
            residue_reg <= zero_reg ? '0 : acc_a_reg;
        end
    end

    assign stat.finish     = zero_reg | (exp_reg == '0);
    assign stat.exp_lsb    = exp_reg[0];
    assign stat.pipe_busy  = mm_busy;
    assign stat.recip_busy = recip_busy;
    assign residue         = residue_reg;
    assign modulus         = modulus_reg;

endmodule

>>> rtl/fmp_ctrl.sv
// Controller: sequences load, per-bit product issue, drain and result
// handoff, and owns the stream handshakes. Depends on fmp_pkg.
module fmp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    output logic               m_tvalid,
    input  logic               m_tready,
    input  fmp_pkg::fmp_stat_t stat,
    output fmp_pkg::fmp_cmd_t  cmd
);

    fmp_pkg::fmp_state_t state_reg, state_next;
    fmp_pkg::fmp_prod_t  k_reg, k_next;
    logic                out_valid_reg, out_valid_next;

    // State, product counter and output valid.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= fmp_pkg::ST_IDLE;
            k_reg         <= fmp_pkg::PROD_AA;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            k_reg         <= k_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Next state and commands.
    always_comb begin
        state_next = state_reg;
        k_next     = k_reg;
        cmd        = '0;
        cmd.sel    = k_reg;
        s_tready   = 1'b0;
        unique case (state_reg)
            fmp_pkg::ST_IDLE: begin
                s_tready = !stat.recip_busy;
                if (s_tvalid && !stat.recip_busy) begin
                    cmd.load   = 1'b1;
                    state_next = fmp_pkg::ST_CHECK;
                end
            end
            fmp_pkg::ST_CHECK: begin
                state_next = stat.finish ? fmp_pkg::ST_DONE : fmp_pkg::ST_PREP;
            end
            fmp_pkg::ST_PREP: begin
                // Skip the accumulator products when the exponent bit is clear.
                cmd.prep   = 1'b1;
                k_next     = stat.exp_lsb ? fmp_pkg::PROD_AA : fmp_pkg::PROD_SQ_AA;
                state_next = fmp_pkg::ST_ISSUE;
            end
            fmp_pkg::ST_ISSUE: begin
                cmd.issue = 1'b1;
                if (k_reg == fmp_pkg::PROD_SQ_BC) begin
                    state_next = fmp_pkg::ST_WAIT;
                end else begin
                    k_next = fmp_pkg::fmp_prod_t'(k_reg + 3'd1);
                end
            end
            fmp_pkg::ST_WAIT: begin
                if (!stat.pipe_busy) begin
                    cmd.shift  = 1'b1;
                    state_next = fmp_pkg::ST_CHECK;
                end
            end
            fmp_pkg::ST_DONE: begin
                if (!out_valid_reg || m_tready) begin
                    cmd.emit   = 1'b1;
                    state_next = fmp_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = fmp_pkg::ST_IDLE;
            end
        endcase
    end

    // Result register valid: set on emit, cleared when the word is taken.
    assign out_valid_next = cmd.emit | (out_valid_reg & ~m_tready);
    assign m_tvalid       = out_valid_reg;

endmodule

>>> sim/fmp_checker.sv
// Checker for the Fibonacci residue block: watches the modulus port and both streams.
// It predicts F(n) mod modulus for each accepted index and compares the residue words.
// Depends on fmp_pkg for widths and the modulus reset value.
module fmp_checker #(
    parameter int INDEX_BITS = fmp_pkg::INDEX_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_we,
    input  logic [fmp_pkg::MOD_W-1:0]     cfg_wdata,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    input  logic [fmp_pkg::INDEX_W-1:0]   s_tdata,   // [39:0] index
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    input  logic [fmp_pkg::RESIDUE_W-1:0] m_tdata,   // [15:0] residue
    output int                            mismatches,
    output int                            outstanding,
    output int                            words_checked
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [fmp_pkg::MOD_W-1:0]     modulus_copy;
    logic [fmp_pkg::RESIDUE_W-1:0] residue_q[$];
    int                            err_count;
    int                            word_count;

    // One entry of a 2x2 product: (x0*y0 + x1*y1) mod m, each term reduced first.
    function automatic longint unsigned dot_mod(longint unsigned x0, longint unsigned y0,
                                                longint unsigned x1, longint unsigned y1,
                                                longint unsigned m);
        return ((x0 * y0) % m + (x1 * y1) % m) % m;
    endfunction

    // Square-and-multiply of [[1,1],[1,0]] to the power n-1; the top-left entry is F(n).
    function automatic logic [fmp_pkg::RESIDUE_W-1:0] fib_residue(
            logic [fmp_pkg::INDEX_W-1:0] index, logic [fmp_pkg::MOD_W-1:0] modulus);
        longint unsigned m, n, e;
        longint unsigned b00, b01, b10, b11;
        longint unsigned a00, a01, a10, a11;
        longint unsigned t00, t01, t10, t11;
        n = 64'(index) & ((64'd1 << INDEX_BITS) - 64'd1);
        m = 64'(modulus);
        if (m < 2 || n == 0)
            return '0;
        b00 = 1; b01 = 1; b10 = 1; b11 = 0;
        a00 = 1; a01 = 0; a10 = 0; a11 = 1;
        e = n - 1;
        while (e != 0) begin
            if (e[0]) begin
                t00 = dot_mod(b00, a00, b01, a10, m);
                t01 = dot_mod(b00, a01, b01, a11, m);
                t10 = dot_mod(b10, a00, b11, a10, m);
                t11 = dot_mod(b10, a01, b11, a11, m);
                a00 = t00; a01 = t01; a10 = t10; a11 = t11;
            end
            t00 = dot_mod(b00, b00, b01, b10, m);
            t01 = dot_mod(b00, b01, b01, b11, m);
            t10 = dot_mod(b10, b00, b11, b10, m);
            t11 = dot_mod(b10, b01, b11, b11, m);
            b00 = t00; b01 = t01; b10 = t10; b11 = t11;
            e = e >> 1;
        end
        return a00[fmp_pkg::RESIDUE_W-1:0];
    endfunction

    // Track the modulus, queue a prediction per accepted index, and check each residue word.
    // A word accepted at an edge is popped before that edge's index is pushed.
    always @(posedge aclk) begin
        logic [fmp_pkg::RESIDUE_W-1:0] want;
        if (!aresetn) begin
            modulus_copy = fmp_pkg::MOD_RESET;
            residue_q.delete();
            err_count = 0;
            word_count = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                word_count++;
                if (residue_q.size() == 0) begin
                    $error("residue: expected nothing, got %0d", m_tdata);
                    err_count++;
                end else begin
                    want = residue_q.pop_front();
                    if (m_tdata !== want) begin
                        $error("residue: expected %0d, got %0d", want, m_tdata);
                        err_count++;
                    end
                end
            end
            if (s_tvalid && s_tready)
                residue_q.push_back(fib_residue(s_tdata, modulus_copy));
            if (cfg_we)
                modulus_copy = cfg_wdata;
        end
        mismatches    <= err_count;
        outstanding   <= residue_q.size();
        words_checked <= word_count;
    end

endmodule

>>> sim/tb.sv
// Top of the testbench for fibonacci_mod_matrix_power: clock, reset and stimulus.
// Instantiates the block and fmp_checker, which predicts and compares; uses fmp_pkg.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1_500_000;
    localparam int HOLD_CYCLES = 2500;

    logic                          aclk;
    logic                          aresetn;
    logic                          cfg_we;
    logic [fmp_pkg::MOD_W-1:0]     cfg_wdata;
    logic                          s_tvalid;
    logic                          s_tready;
    logic [fmp_pkg::INDEX_W-1:0]   s_tdata;   // [39:0] index
    logic                          m_tvalid;
    logic                          m_tready;
    logic [fmp_pkg::RESIDUE_W-1:0] m_tdata;   // [15:0] residue

    int  mismatches;
    int  outstanding;
    int  words_checked;
    int  send_pct;
    int  stall_pct;
    bit  hold_start;
    int  hold_left;
    int  cycle_count;
    int  indices_sent;
    int  modulus_writes;

    fibonacci_mod_matrix_power dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    fmp_checker chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .mismatches   (mismatches),
        .outstanding  (outstanding),
        .words_checked(words_checked)
    );

    // 12 ns clock.
    initial aclk = 1'b0;
    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Result side: random stalls, or a long hold-off when one is requested.
    always @(posedge aclk) begin
        if (hold_start) begin
            hold_start = 1'b0;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    // Watchdog on the whole run.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Random index: mostly random bit lengths, some full-width words, some tiny values.
    function automatic logic [fmp_pkg::INDEX_W-1:0] rand_index(bit short_only);
        int          kind;
        int          len;
        logic [63:0] v;
        v = {$urandom, $urandom};
        kind = $urandom_range(99);
        if (short_only)
            len = $urandom_range(1, 8);
        else if (kind < 20)
            return v[fmp_pkg::INDEX_W-1:0];
        else if (kind < 35)
            return fmp_pkg::INDEX_W'($urandom_range(200));
        else
            len = $urandom_range(1, fmp_pkg::INDEX_W);
        v = v & ((64'd1 << len) - 64'd1);
        v[len-1] = 1'b1;
        return v[fmp_pkg::INDEX_W-1:0];
    endfunction

    // Offer one index word, after a random gap, and wait until it is taken.
    task automatic send_index(input logic [fmp_pkg::INDEX_W-1:0] index);
        while ($urandom_range(99) < send_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= index;
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        indices_sent++;
    endtask

    // Stop offering and wait until every predicted residue has come out.
    // The first edge lets the checker count a word accepted just before.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (outstanding != 0)
            @(posedge aclk);
    endtask

    // Modulus writes happen only with the block idle.
    task automatic write_modulus(input logic [fmp_pkg::MOD_W-1:0] modulus);
        drain();
        repeat (4) @(posedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= modulus;
        @(posedge aclk);
        cfg_we <= 1'b0;
        modulus_writes++;
    endtask

    task automatic run_random(input int count, input int send_idle, input int recv_stall);
        send_pct  = send_idle;
        stall_pct = recv_stall;
        repeat (count) send_index(rand_index(1'b0));
    endtask

    // Stimulus: directed corners, then random phases under several idle patterns.
    initial begin
        aresetn        <= 1'b0;
        cfg_we         <= 1'b0;
        cfg_wdata      <= '0;
        s_tvalid       <= 1'b0;
        s_tdata        <= '0;
        m_tready       <= 1'b0;
        send_pct       = 0;
        stall_pct      = 0;
        hold_start     = 1'b0;
        hold_left      = 0;
        cycle_count    = 0;
        indices_sent   = 0;
        modulus_writes = 0;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset modulus: index zero, index one, small values and full-width patterns.
        send_index(40'd0);
        send_index(40'd1);
        send_index(40'd2);
        send_index(40'd3);
        send_index(40'd10);
        send_index(40'hFF_FFFF_FFFF);
        send_index(40'h80_0000_0000);
        send_index(40'h55_5555_5555);
        send_index(40'hAA_AAAA_AAAA);

        // Largest and smallest meaningful moduli.
        write_modulus(16'd65535);
        send_index(40'd1);
        send_index(40'hFF_FFFF_FFFF);
        send_index(40'd1000);
        write_modulus(16'd2);
        send_index(40'd1);
        send_index(40'd3);
        send_index(40'hFF_FFFF_FFFF);

        // A modulus of zero or one gives a zero residue.
        write_modulus(16'd0);
        send_index(40'd0);
        send_index(40'd1);
        send_index(40'd5);
        write_modulus(16'd1);
        send_index(40'd1);
        send_index(40'd7);

        // Random phases.
        write_modulus(16'($urandom_range(2, 65535)));
        run_random(60, 0, 0);
        write_modulus(16'd65535);
        run_random(60, 58, 0);
        write_modulus(16'd3);
        run_random(50, 0, 58);
        write_modulus(16'($urandom_range(2, 65535)));
        run_random(60, 12, 12);

        // Long hold on the result side while short indices keep coming.
        write_modulus(16'($urandom_range(65535)));
        send_pct  = 0;
        stall_pct = 0;
        hold_start = 1'b1;
        repeat (25) send_index(rand_index(1'b1));

        // Sender pauses midway until every residue has come out.
        write_modulus(16'($urandom_range(2, 65535)));
        run_random(30, 58, 0);
        drain();
        run_random(30, 0, 58);

        write_modulus(16'd1);
        run_random(8, 0, 0);
        write_modulus(16'd0);
        run_random(8, 12, 12);
        write_modulus(16'($urandom_range(2, 65535)));
        run_random(80, 12, 12);

        // Wait out the tail so that a stray word would still be caught.
        drain();
        stall_pct = 0;
        repeat (60) @(posedge aclk);

        $display("Sent %0d indices under %0d modulus settings; checked %0d residue words.",
                 indices_sent, modulus_writes + 1, words_checked);
        $display("Covered idle and stall phases, a long output hold and a drained pause.");
        if (mismatches == 0 && outstanding == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> filelist.f
+incdir+rtl
rtl/fmp_pkg.sv
rtl/fmp_mulmod.sv
rtl/fmp_recip.sv
rtl/fmp_datapath.sv
rtl/fmp_ctrl.sv
rtl/fibonacci_mod_matrix_power.sv
sim/fmp_checker.sv
sim/tb.sv
